// ----- design/pctd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the prefix-code trie decoder.
// Used by every module of the block; depends on nothing.
package pctd_pkg;

    localparam int MAX_NODES_DEF = 512;
    localparam int MAX_CODE_LEN  = 32;
    localparam int SYMBOLS       = 256;

    localparam int SYM_W      = 8;
    localparam int CODE_W     = 32;
    localparam int CODE_LEN_W = 6;
    localparam int BYTE_W     = 8;
    localparam int BIT_CNT_W  = 4;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 8;

    localparam int RES_DEPTH = 8;
    localparam int RES_CNT_W = 4;
    localparam int RES_IDX_W = 3;

    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam logic [CODE_LEN_W-1:0] LEN_MAX   = LEN_LIMIT[CODE_LEN_W-1:0];
    localparam logic [SYM_W:0]        SYM_LIMIT = SYMBOLS[SYM_W:0];
    localparam logic [BIT_CNT_W-1:0]  BITS_MAX  = BYTE_W[BIT_CNT_W-1:0];

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_INSERT  = 2'd1,
        OP_DECODE  = 2'd2,
        OP_RESTART = 2'd3
    } pctd_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PATH = 2'd1,
        ST_FULL     = 2'd2
    } pctd_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_PREP,
        S_INS_READ,
        S_INS_STEP,
        S_INS_ALLOC,
        S_INS_LINK,
        S_DEC_WALK
    } pctd_state_t;

    typedef struct packed {
        logic zero_we;
        logic one_we;
        logic label_we;
    } pctd_tbl_we_t;

    typedef struct packed {
        logic               push;
        logic [SYM_W-1:0]   symbol;
        logic               fail;
        pctd_status_t       fail_status;
        logic               done;
    } pctd_res_ctl_t;

endpackage

// ----- design/pctd_node_table.sv -----
`timescale 1ns / 1ps
// Node table of the code trie: zero-child, one-child and label memories.
// One write address and one registered read address per cycle; uses pctd_pkg.
module pctd_node_table
    import pctd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                         aclk,
    input  pctd_tbl_we_t                 we,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  logic [$clog2(MAX_NODES)-1:0] child_wdata,
    input  logic [SYM_W-1:0]             label_wdata,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    output logic [$clog2(MAX_NODES)-1:0] rd_zero,
    output logic [$clog2(MAX_NODES)-1:0] rd_one,
    output logic [SYM_W-1:0]             rd_label
);

    localparam int NW = $clog2(MAX_NODES);

    logic [NW-1:0]    zero_mem  [MAX_NODES];
    logic [NW-1:0]    one_mem   [MAX_NODES];
    logic [SYM_W-1:0] label_mem [MAX_NODES];

    logic [NW-1:0]    zero_rd_reg;
    logic [NW-1:0]    one_rd_reg;
    logic [SYM_W-1:0] label_rd_reg;

    always_ff @(posedge aclk) begin
        if (we.zero_we) begin
            zero_mem[wr_addr] <= child_wdata;
        end
        if (we.one_we) begin
            one_mem[wr_addr] <= child_wdata;
        end
        if (we.label_we) begin
            label_mem[wr_addr] <= label_wdata;
        end
        zero_rd_reg  <= zero_mem[rd_addr];
        one_rd_reg   <= one_mem[rd_addr];
        label_rd_reg <= label_mem[rd_addr];
    end

    assign rd_zero  = zero_rd_reg;
    assign rd_one   = one_rd_reg;
    assign rd_label = label_rd_reg;

endmodule

// ----- design/pctd_result_buffer.sv -----
`timescale 1ns / 1ps
// Result buffer: collects the symbols of one item, replaces them on error,
// and plays them out as master-side beats. Uses pctd_pkg.
module pctd_result_buffer
    import pctd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pctd_res_ctl_t        ctl,
    output logic                 busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] symbol_out
    output logic [1:0]           m_tuser,   // [1:0] status
    output logic                 m_tlast
);

    logic [SYM_W-1:0]     sym_buf_reg [RES_DEPTH];
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [RES_IDX_W-1:0] idx_reg, idx_next;
    pctd_status_t         status_reg, status_next;
    logic                 emit_reg, emit_next;

    logic                 buf_we;
    logic [RES_IDX_W-1:0] buf_idx;
    logic [SYM_W-1:0]     buf_data;
    logic                 last_beat;

    assign last_beat = (RES_CNT_W'(idx_reg) + 1'b1) == count_reg;

    always_comb begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        emit_next   = emit_reg;
        buf_we      = 1'b0;
        buf_idx     = count_reg[RES_IDX_W-1:0];
        buf_data    = ctl.symbol;
        if (emit_reg) begin
            if (m_tready) begin
                if (last_beat) begin
                    emit_next   = 1'b0;
                    count_next  = '0;
                    idx_next    = '0;
                    status_next = ST_OK;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end else begin
            if (ctl.fail) begin
                buf_we      = 1'b1;
                buf_idx     = '0;
                buf_data    = '0;
                count_next  = RES_CNT_W'(1);
                status_next = ctl.fail_status;
            end else if (ctl.push) begin
                buf_we     = 1'b1;
                count_next = count_reg + 1'b1;
            end
            if (ctl.done && count_next != '0) begin
                emit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= ST_OK;
            emit_reg   <= 1'b0;
        end else begin
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            emit_reg   <= emit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            sym_buf_reg[buf_idx] <= buf_data;
        end
    end

    assign busy     = emit_reg;
    assign m_tvalid = emit_reg;
    assign m_tdata  = sym_buf_reg[idx_reg];
    assign m_tuser  = status_reg;
    assign m_tlast  = last_beat;

endmodule

// ----- design/pctd_sequencer.sv -----
`timescale 1ns / 1ps
// Sequencer: walks the trie one code bit per step for insert and decode,
// allocates nodes and drives the node table and result buffer. Uses pctd_pkg.
module pctd_sequencer
    import pctd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [S_TDATA_W-1:0]         s_tdata,
    input  logic [1:0]                   s_tuser,
    input  logic                         busy,
    output pctd_tbl_we_t                 tbl_we,
    output logic [$clog2(MAX_NODES)-1:0] wr_addr,
    output logic [$clog2(MAX_NODES)-1:0] child_wdata,
    output logic [SYM_W-1:0]             label_wdata,
    output logic [$clog2(MAX_NODES)-1:0] rd_addr,
    input  logic [$clog2(MAX_NODES)-1:0] rd_zero,
    input  logic [$clog2(MAX_NODES)-1:0] rd_one,
    input  logic [SYM_W-1:0]             rd_label,
    output pctd_res_ctl_t                res_ctl
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int NU_W = $clog2(MAX_NODES + 1);
    localparam logic [NU_W-1:0] NODE_LIMIT = NU_W'(MAX_NODES);

    pctd_state_t           state_reg, state_next;
    logic [NU_W-1:0]       nodes_used_reg, nodes_used_next;
    logic [NW-1:0]         walk_reg, walk_next;
    logic                  root_cleared_reg, root_cleared_next;
    logic                  fresh_reg, fresh_next;
    logic [NW-1:0]         node_reg, node_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [CODE_LEN_W-1:0] rem_reg, rem_next;
    logic [BYTE_W-1:0]     data_reg, data_next;
    logic [BIT_CNT_W-1:0]  bits_reg, bits_next;

    pctd_op_t              in_op;
    logic [SYM_W-1:0]      in_sym;
    logic [CODE_W-1:0]     in_code;
    logic [CODE_LEN_W-1:0] in_len;
    logic [BYTE_W-1:0]     in_data;
    logic [BIT_CNT_W-1:0]  in_cnt;
    logic [CODE_LEN_W-1:0] len_sat;
    logic [BIT_CNT_W-1:0]  cnt_sat;
    logic [SYM_W:0]        sym_diff;
    logic [NW-1:0]         new_node;
    logic [NW-1:0]         ins_child;
    logic [NW-1:0]         dec_child;
    logic                  is_leaf;

    assign in_op   = pctd_op_t'(s_tuser);
    assign in_sym  = s_tdata[7:0];
    assign in_code = s_tdata[39:8];
    assign in_len  = s_tdata[45:40];
    assign in_data = s_tdata[53:46];
    assign in_cnt  = s_tdata[57:54];

    assign len_sat   = (in_len > LEN_MAX) ? LEN_MAX : in_len;
    assign cnt_sat   = (in_cnt > BITS_MAX) ? BITS_MAX : in_cnt;
    assign sym_diff  = {1'b0, sym_reg} - SYM_LIMIT;
    assign new_node  = nodes_used_reg[NW-1:0];
    assign ins_child = code_reg[0] ? rd_one : rd_zero;
    assign dec_child = (walk_reg == '0 && root_cleared_reg) ? '0
                     : (data_reg[BYTE_W-1] ? rd_one : rd_zero);
    assign is_leaf   = (rd_zero == '0) && (rd_one == '0);

    always_comb begin
        state_next        = state_reg;
        nodes_used_next   = nodes_used_reg;
        walk_next         = walk_reg;
        root_cleared_next = root_cleared_reg;
        fresh_next        = fresh_reg;
        node_next         = node_reg;
        sym_next          = sym_reg;
        code_next         = code_reg;
        rem_next          = rem_reg;
        data_next         = data_reg;
        bits_next         = bits_reg;
        s_tready          = 1'b0;
        tbl_we            = '0;
        wr_addr           = node_reg;
        child_wdata       = '0;
        label_wdata       = sym_reg;
        rd_addr           = node_reg;
        res_ctl           = '0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = !busy;
                rd_addr  = walk_reg;
                if (s_tvalid && !busy) begin
                    unique case (in_op)
                        OP_CLEAR: begin
                            nodes_used_next   = NU_W'(1);
                            root_cleared_next = 1'b1;
                            walk_next         = '0;
                        end
                        OP_RESTART: begin
                            walk_next = '0;
                        end
                        OP_INSERT: begin
                            sym_next   = in_sym;
                            code_next  = in_code;
                            rem_next   = len_sat;
                            node_next  = '0;
                            state_next = S_INS_PREP;
                        end
                        OP_DECODE: begin
                            data_next  = in_data;
                            bits_next  = cnt_sat;
                            fresh_next = 1'b0;
                            state_next = S_DEC_WALK;
                        end
                    endcase
                end
            end

            S_INS_PREP: begin
                if ({1'b0, sym_reg} >= SYM_LIMIT) begin
                    sym_next = sym_diff[SYM_W-1:0];
                end else begin
                    state_next = S_INS_READ;
                end
                if (root_cleared_reg) begin
                    wr_addr           = '0;
                    tbl_we            = '1;
                    label_wdata       = '0;
                    root_cleared_next = 1'b0;
                end
            end

            S_INS_READ: begin
                state_next = S_INS_STEP;
            end

            S_INS_STEP: begin
                if (rem_reg == '0) begin
                    tbl_we.label_we = 1'b1;
                    res_ctl.done    = 1'b1;
                    state_next      = S_IDLE;
                end else if (ins_child != '0) begin
                    node_next = ins_child;
                    rd_addr   = ins_child;
                    rem_next  = rem_reg - 1'b1;
                    code_next = code_reg >> 1;
                end else if (nodes_used_reg >= NODE_LIMIT) begin
                    res_ctl.fail        = 1'b1;
                    res_ctl.fail_status = ST_FULL;
                    res_ctl.done        = 1'b1;
                    state_next          = S_IDLE;
                end else begin
                    state_next = S_INS_ALLOC;
                end
            end

            S_INS_ALLOC: begin
                wr_addr     = new_node;
                tbl_we      = '1;
                label_wdata = '0;
                state_next  = S_INS_LINK;
            end

            S_INS_LINK: begin
                wr_addr         = node_reg;
                child_wdata     = new_node;
                tbl_we.zero_we  = !code_reg[0];
                tbl_we.one_we   = code_reg[0];
                node_next       = new_node;
                rd_addr         = new_node;
                nodes_used_next = nodes_used_reg + 1'b1;
                rem_next        = rem_reg - 1'b1;
                code_next       = code_reg >> 1;
                state_next      = S_INS_STEP;
            end

            S_DEC_WALK: begin
                rd_addr = walk_reg;
                if (fresh_reg && is_leaf) begin
                    res_ctl.push   = 1'b1;
                    res_ctl.symbol = rd_label;
                    walk_next      = '0;
                    rd_addr        = '0;
                    fresh_next     = 1'b0;
                end else if (bits_reg == '0) begin
                    res_ctl.done = 1'b1;
                    fresh_next   = 1'b0;
                    state_next   = S_IDLE;
                end else if (dec_child == '0) begin
                    res_ctl.fail        = 1'b1;
                    res_ctl.fail_status = ST_BAD_PATH;
                    res_ctl.done        = 1'b1;
                    walk_next           = '0;
                    fresh_next          = 1'b0;
                    state_next          = S_IDLE;
                end else begin
                    walk_next  = dec_child;
                    rd_addr    = dec_child;
                    fresh_next = 1'b1;
                    bits_next  = bits_reg - 1'b1;
                    data_next  = data_reg << 1;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            nodes_used_reg   <= NU_W'(1);
            walk_reg         <= '0;
            root_cleared_reg <= 1'b1;
            fresh_reg        <= 1'b0;
        end else begin
            state_reg        <= state_next;
            nodes_used_reg   <= nodes_used_next;
            walk_reg         <= walk_next;
            root_cleared_reg <= root_cleared_next;
            fresh_reg        <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        sym_reg  <= sym_next;
        code_reg <= code_next;
        rem_reg  <= rem_next;
        data_reg <= data_next;
        bits_reg <= bits_next;
    end

endmodule

// ----- design/prefix_code_trie_decoder_unit.sv -----
`timescale 1ns / 1ps
// Prefix-code trie decoder: top level, sequencer + node table + result buffer.
// Throughput: one item at a time, each code bit waits on one node-table read.
// After the item finishes, results leave one beat per cycle while m_tready is high; input waits meanwhile.
// Reset: control cleared, trie holds the root only; node memories are not swept.
module prefix_code_trie_decoder_unit
    import pctd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] symbol_in, [39:8] code_bits, [45:40] code_length,
    // [53:46] data_byte, [57:54] bit_count, [63:58] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,   // [1:0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] symbol_out
    output logic [1:0]           m_tuser,   // [1:0] status
    output logic                 m_tlast
);

    localparam int NW = $clog2(MAX_NODES);

    pctd_tbl_we_t     tbl_we;
    logic [NW-1:0]    wr_addr;
    logic [NW-1:0]    child_wdata;
    logic [SYM_W-1:0] label_wdata;
    logic [NW-1:0]    rd_addr;
    logic [NW-1:0]    rd_zero;
    logic [NW-1:0]    rd_one;
    logic [SYM_W-1:0] rd_label;
    pctd_res_ctl_t    res_ctl;
    logic             busy;

    pctd_sequencer #(
        .MAX_NODES(MAX_NODES)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .busy       (busy),
        .tbl_we     (tbl_we),
        .wr_addr    (wr_addr),
        .child_wdata(child_wdata),
        .label_wdata(label_wdata),
        .rd_addr    (rd_addr),
        .rd_zero    (rd_zero),
        .rd_one     (rd_one),
        .rd_label   (rd_label),
        .res_ctl    (res_ctl)
    );

    pctd_node_table #(
        .MAX_NODES(MAX_NODES)
    ) u_table (
        .aclk       (aclk),
        .we         (tbl_we),
        .wr_addr    (wr_addr),
        .child_wdata(child_wdata),
        .label_wdata(label_wdata),
        .rd_addr    (rd_addr),
        .rd_zero    (rd_zero),
        .rd_one     (rd_one),
        .rd_label   (rd_label)
    );

    pctd_result_buffer u_res (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (res_ctl),
        .busy    (busy),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ----- bench/prefix_code_trie_decoder_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for prefix_code_trie_decoder_unit: random prefix code sets, decode runs,
// table overflow and noise, checked beat by beat against an in-bench trie predictor.
// Depends on pctd_pkg and the decoder RTL only.
module prefix_code_trie_decoder_unit_test;
    import pctd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 115;

    typedef struct packed {
        pctd_op_t    op;
        logic [7:0]  sym;
        logic [31:0] code;
        logic [5:0]  len;
        logic [7:0]  data;
        logic [3:0]  cnt;
    } trie_item_t;

    typedef struct {
        logic [7:0]   sym;
        pctd_status_t st;
        logic         last;
    } symbol_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    trie_item_t   pending_beats[$];
    symbol_beat_t expected_symbols[$];
    trie_item_t   drv_next;
    trie_item_t   on_wire;
    int           items_made = 0;
    int           beats_taken = 0;
    int           error_count = 0;
    int           cycles = 0;

    // predictor copy of the trie
    logic [8:0]   zero_child[MAX_NODES_DEF];
    logic [8:0]   one_child[MAX_NODES_DEF];
    logic [7:0]   node_label[MAX_NODES_DEF];
    int           nodes_used = 1;
    logic [8:0]   walk_node = '0;
    logic         root_cleared = 1'b1;

    prefix_code_trie_decoder_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [8:0] trie_child(input logic [8:0] node, input logic b);
        if (node == 0 && root_cleared)
            return '0;
        return b ? one_child[node] : zero_child[node];
    endfunction

    task automatic trie_step(input trie_item_t it);
        logic [8:0]   node;
        logic [8:0]   nxt;
        logic [7:0]   hits[$];
        symbol_beat_t res;
        int           len;
        int           cnt;
        logic         stop;
        node = '0;
        stop = 1'b0;
        case (it.op)
            OP_CLEAR: begin
                nodes_used = 1;
                root_cleared = 1'b1;
                walk_node = '0;
            end
            OP_RESTART: begin
                walk_node = '0;
            end
            OP_INSERT: begin
                len = (it.len > LEN_MAX) ? int'(LEN_MAX) : int'(it.len);
                if (root_cleared) begin
                    zero_child[0] = '0;
                    one_child[0] = '0;
                    node_label[0] = '0;
                    root_cleared = 1'b0;
                end
                for (int k = 0; k < len && !stop; k++) begin
                    nxt = trie_child(node, it.code[k]);
                    if (nxt == 0) begin
                        if (nodes_used >= MAX_NODES_DEF) begin
                            stop = 1'b1;
                            res.sym = '0;
                            res.st = ST_FULL;
                            res.last = 1'b1;
                            expected_symbols = {expected_symbols, res};
                        end else begin
                            nxt = nodes_used[8:0];
                            nodes_used++;
                            zero_child[nxt] = '0;
                            one_child[nxt] = '0;
                            node_label[nxt] = '0;
                            if (it.code[k])
                                one_child[node] = nxt;
                            else
                                zero_child[node] = nxt;
                        end
                    end
                    if (!stop)
                        node = nxt;
                end
                if (!stop)
                    node_label[node] = it.sym;
            end
            default: begin
                cnt = (it.cnt > BITS_MAX) ? int'(BITS_MAX) : int'(it.cnt);
                for (int i = 0; i < cnt && !stop; i++) begin
                    nxt = trie_child(walk_node, it.data[7 - i]);
                    if (nxt == 0) begin
                        stop = 1'b1;
                        walk_node = '0;
                    end else begin
                        walk_node = nxt;
                        if (zero_child[nxt] == 0 && one_child[nxt] == 0) begin
                            hits = {hits, node_label[nxt]};
                            walk_node = '0;
                        end
                    end
                end
                if (stop) begin
                    res.sym = '0;
                    res.st = ST_BAD_PATH;
                    res.last = 1'b1;
                    expected_symbols = {expected_symbols, res};
                end else begin
                    foreach (hits[h]) begin
                        res.sym = hits[h];
                        res.st = ST_OK;
                        res.last = (h == hits.size() - 1);
                        expected_symbols = {expected_symbols, res};
                    end
                end
            end
        endcase
    endtask

    // fields that the operation ignores still carry random values
    function automatic trie_item_t any_item(input pctd_op_t op);
        trie_item_t it;
        it.op = op;
        it.sym = 8'($urandom);
        it.code = $urandom;
        it.len = 6'($urandom_range(0, 63));
        it.data = 8'($urandom);
        it.cnt = 4'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic add_ctl(input pctd_op_t op);
        pending_beats = {pending_beats, any_item(op)};
        items_made++;
    endtask

    task automatic add_insert(input logic [31:0] code, input int len, input logic [7:0] sym);
        trie_item_t it;
        it = any_item(OP_INSERT);
        it.code = code;
        it.len = len[5:0];
        it.sym = sym;
        pending_beats = {pending_beats, it};
        items_made++;
    endtask

    task automatic add_decode(input logic [7:0] data, input int cnt);
        trie_item_t it;
        it = any_item(OP_DECODE);
        it.data = data;
        it.cnt = cnt[3:0];
        pending_beats = {pending_beats, it};
        items_made++;
    endtask

    task automatic add_decodes(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                add_ctl(OP_RESTART);
            else
                add_decode(8'($urandom),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 8);
        end
    endtask

    // split random leaves until the code set has the wanted size or 200 tries are spent; drop some codes when partial
    task automatic add_code_set(input int leaves, input int max_depth, input logic partial);
        logic [31:0] paths[$];
        int          depths[$];
        int          j;
        int          tries;
        paths = {paths, 32'd0};
        depths = {depths, 0};
        tries = 0;
        while (paths.size() < leaves && tries < 200) begin
            j = $urandom_range(0, paths.size() - 1);
            tries++;
            if (depths[j] < max_depth) begin
                paths = {paths, paths[j] | (32'd1 << depths[j])};
                depths = {depths, depths[j] + 1};
                depths[j] = depths[j] + 1;
            end
        end
        foreach (paths[k])
            if (!partial || $urandom_range(0, 3) != 0)
                add_insert(paths[k], depths[k], 8'($urandom));
    endtask

    // driver: bursts of random length, random gaps between them
    int gap_left = 0;
    int burst_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                trie_step(on_wire);
                beats_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pending_beats.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end else begin
                    drv_next = pending_beats.pop_front();
                    s_tdata <= {6'd0, drv_next.cnt, drv_next.data, drv_next.len,
                                drv_next.code, drv_next.sym};
                    s_tuser <= drv_next.op;
                    s_tvalid <= 1'b1;
                    on_wire <= drv_next;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    // receiver: stall modes that rotate, plus one long hold-off
    int         rx_cycles = 0;
    int         rx_mode = 0;
    int         rx_phase = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    logic [7:0] rx_pattern = 8'b1011_0010;
    symbol_beat_t got;

    always @(posedge aclk) begin
        rx_cycles++;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_symbols.size() == 0) begin
                    $error("unexpected beat: symbol_out=%0d status=%0d last=%0d",
                           m_tdata, m_tuser, m_tlast);
                    error_count++;
                end else begin
                    got = expected_symbols.pop_front();
                    if (m_tdata !== got.sym) begin
                        $error("symbol_out: expected %0d, got %0d", got.sym, m_tdata);
                        error_count++;
                    end
                    if (m_tuser !== got.st) begin
                        $error("status: expected %0d, got %0d", got.st, m_tuser);
                        error_count++;
                    end
                    if (m_tlast !== got.last) begin
                        $error("last: expected %0d, got %0d", got.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && m_tvalid && rx_cycles > 1500) begin
                hold_done = 1'b1;
                hold_left = 500;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 2) != 0);
                    2: m_tready <= rx_pattern[0];
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
                rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                rx_phase++;
                if (rx_phase >= 60) begin
                    rx_phase = 0;
                    rx_mode = $urandom_range(0, 3);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int start;
        int pick;
        // directed: empty trie, one-bit codes, prefix conflict, walk carry-over, restart, clear, over-long codes
        add_decode(8'hFF, 8);
        add_decode(8'h00, 0);
        add_insert(32'd0, 0, 8'h5A);
        add_insert(32'd0, 1, 8'hFF);
        add_insert(32'd1, 1, 8'h00);
        add_decode(8'b0101_0101, 8);
        add_decode(8'b1010_1010, 15);
        add_insert(32'b10, 2, 8'h3C);
        add_decode(8'b0110_0000, 3);
        add_decode(8'b1000_0000, 3);
        add_decode(8'b0000_0000, 1);
        add_decode(8'b1000_0000, 1);
        add_decode(8'b0000_0000, 1);
        add_ctl(OP_RESTART);
        add_decode(8'b1111_1111, 1);
        add_insert(32'hFFFF_FFFF, 63, 8'hA5);
        add_decode(8'hFF, 8);
        add_decode(8'hFF, 9);
        add_ctl(OP_RESTART);
        add_ctl(OP_CLEAR);
        add_decode(8'h00, 8);
        add_insert(32'h8000_0000, 32, 8'h81);
        add_insert(32'h7FFF_FFFF, 40, 8'h7E);
        add_decode(8'h7F, 8);
        // random: fill the table to overflow first, then code-set episodes and noise
        start = items_made;
        add_ctl(OP_CLEAR);
        for (int i = 0; i < 22; i++)
            add_insert($urandom, $urandom_range(32, 63), 8'($urandom));
        add_decodes(6);
        while (items_made - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                add_ctl(OP_CLEAR);
                add_code_set($urandom_range(2, 12), $urandom_range(3, 12), 1'b0);
                add_decodes($urandom_range(4, 12));
            end else if (pick <= 8) begin
                if ($urandom_range(0, 1) == 0)
                    add_ctl(OP_CLEAR);
                add_code_set($urandom_range(2, 10), $urandom_range(2, 8), 1'b1);
                add_decodes($urandom_range(3, 8));
            end else begin
                for (int i = 0; i < 5; i++)
                    pending_beats = {pending_beats,
                                     any_item(pctd_op_t'($urandom_range(0, 3)))};
                items_made += 5;
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(beats_taken == items_made && expected_symbols.size() == 0))
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_symbols.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
